/* src/hfam_pkg.sv */
// ----------------------------------------------------------------------------
// hfam_pkg: shared definitions for the Hopfield associative memory
// Word formats, operation codes, register map and sequencer states.
// ----------------------------------------------------------------------------
package hfam_pkg;

    localparam int NEURONS_DEF      = 64;
    localparam int MAX_PATTERNS_DEF = 64;
    localparam logic [7:0] SWEEP_LIMIT_RESET = 8'd60;

    // operation codes carried in the mode field
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_STORE  = 2'd1;
    localparam logic [1:0] MODE_RECALL = 2'd2;

    // register byte addresses
    localparam logic [2:0] ADDR_SWEEP_LIMIT = 3'd0;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] pattern;
        logic [63:0] reference_pattern;
    } in_word_t;

    typedef struct packed {
        logic [63:0] recalled_pattern;
        logic        matches_reference;
        logic        converged;
        logic [7:0]  sweeps_used;
        logic        status;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STORE_RD,
        ST_STORE_WR,
        ST_RECALL_RD,
        ST_RECALL_SUM,
        ST_RECALL_UPD,
        ST_OUT
    } state_t;

endpackage

/* src/hfam_wmem.sv */
// ----------------------------------------------------------------------------
// hfam_wmem: weight row memory
// One row of weights per neuron, one write and one registered read per
// cycle. Per-row valid bits make unwritten or cleared rows read as zero.
// ----------------------------------------------------------------------------
module hfam_wmem #(
    parameter int ROWS  = hfam_pkg::NEURONS_DEF,
    parameter int ROW_W = 512,
    parameter int AW    = $clog2(ROWS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clr,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [ROW_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [ROW_W-1:0] rd_data
);

    logic [ROW_W-1:0] mem [ROWS];
    logic [ROW_W-1:0] rd_raw_reg;
    logic [ROWS-1:0]  valid_reg;
    logic             rd_valid_reg;

    // storage array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    // row valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : '0;

endmodule

/* src/hopfield_associative_memory_top.sv */
// Operation: clear goes straight to output; store reads then writes each row;
// recall runs up to sweep_limit sweeps (one neuron update takes read, partial
// sum and final sum steps on the shared row adder). One word in flight at a time.
// Reset: weights read as zero, pattern count zero, sweep_limit 60.
// ----------------------------------------------------------------------------
// hopfield_associative_memory_top: Hopfield associative memory
// Hebbian store, in-place asynchronous recall over a shared row adder.
// ----------------------------------------------------------------------------
module hopfield_associative_memory_top #(
    parameter int NEURONS      = hfam_pkg::NEURONS_DEF,
    parameter int MAX_PATTERNS = hfam_pkg::MAX_PATTERNS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hfam_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output hfam_pkg::out_word_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int NW    = $clog2(NEURONS);
    localparam int GRP   = (NEURONS + 7) / 8;
    localparam int LANES = GRP * 8;
    localparam int ROW_W = LANES * 8;

    hfam_pkg::state_t state_reg, state_next;

    logic [7:0]         sweep_limit_reg;
    logic [6:0]         stored_count_reg;
    logic [NEURONS-1:0] s_reg;
    logic [NEURONS-1:0] ref_reg;
    logic [NW-1:0]      idx_reg;
    logic [7:0]         sweeps_reg;
    logic               changed_reg;
    logic [11:0]        psum_reg [GRP];
    hfam_pkg::out_word_t out_reg;

    logic               mem_clr, mem_wr, mem_rd;
    logic [ROW_W-1:0]   wr_row, rd_row;
    logic [LANES-1:0]   s_pad;
    logic [11:0]        psum_next [GRP];
    logic [14:0]        h_sum;
    logic               new_bit;
    logic [NEURONS-1:0] s_upd;
    logic               chg;
    logic               last_idx;
    logic [7:0]         sweeps_inc;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr == hfam_pkg::ADDR_SWEEP_LIMIT) ? 32'(sweep_limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_limit_reg <= hfam_pkg::SWEEP_LIMIT_RESET;
        end
        else if (psel && penable && pwrite && paddr == hfam_pkg::ADDR_SWEEP_LIMIT)
        begin
            sweep_limit_reg <= pwdata[7:0];
        end
    end

    // ---------------- weight memory ----------------
    hfam_wmem #(
        .ROWS  (NEURONS),
        .ROW_W (ROW_W),
        .AW    (NW)
    ) u_wmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (mem_clr),
        .wr_en   (mem_wr),
        .wr_addr (idx_reg),
        .wr_data (wr_row),
        .rd_en   (mem_rd),
        .rd_addr (idx_reg),
        .rd_data (rd_row)
    );

    assign mem_clr = (state_reg == hfam_pkg::ST_IDLE) && in_valid
                     && in_data.mode == hfam_pkg::MODE_CLEAR;
    assign mem_wr  = (state_reg == hfam_pkg::ST_STORE_WR);
    assign mem_rd  = (state_reg == hfam_pkg::ST_STORE_RD)
                     || (state_reg == hfam_pkg::ST_RECALL_RD);

    // Hebbian row update with saturation, diagonal untouched
    always_comb
    begin
        logic signed [8:0] w;
        wr_row = rd_row;
        for (int j = 0; j < NEURONS; j++)
        begin
            w = 9'(signed'(rd_row[j*8 +: 8]));
            w = (s_reg[idx_reg] == s_reg[j]) ? w + 9'sd1 : w - 9'sd1;
            if (w > 9'sd127)
            begin
                w = 9'sd127;
            end
            else if (w < -9'sd128)
            begin
                w = -9'sd128;
            end
            if (j != int'(idx_reg))
            begin
                wr_row[j*8 +: 8] = w[7:0];
            end
        end
    end

    // partial sums: one sum of eight weighted terms per group of eight lanes
    assign s_pad = LANES'(s_reg);
    always_comb
    begin
        logic signed [11:0] acc;
        logic signed [8:0]  t;
        for (int g = 0; g < GRP; g++)
        begin
            acc = '0;
            for (int k = 0; k < 8; k++)
            begin
                t = 9'(signed'(rd_row[(g*8+k)*8 +: 8]));
                if (!s_pad[g*8+k])
                begin
                    t = -t;
                end
                if ((g*8+k) < NEURONS)
                begin
                    acc = acc + 12'(t);
                end
            end
            psum_next[g] = acc;
        end
    end

    // final sum and neuron update
    always_comb
    begin
        logic signed [14:0] tot;
        tot = '0;
        for (int g = 0; g < GRP; g++)
        begin
            tot = tot + 15'(signed'(psum_reg[g]));
        end
        h_sum = tot;
    end

    assign new_bit    = ~h_sum[14];
    assign chg        = changed_reg | (new_bit != s_reg[idx_reg]);
    assign last_idx   = (idx_reg == NW'(NEURONS - 1));
    assign sweeps_inc = sweeps_reg + 8'd1;

    always_comb
    begin
        s_upd          = s_reg;
        s_upd[idx_reg] = new_bit;
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hfam_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hfam_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (in_data.mode == hfam_pkg::MODE_STORE
                                 && stored_count_reg < 7'(MAX_PATTERNS))
                    begin
                        state_next = hfam_pkg::ST_STORE_RD;
                    end
                    else if (in_data.mode == hfam_pkg::MODE_RECALL && sweep_limit_reg != 8'd0)
                    begin
                        state_next = hfam_pkg::ST_RECALL_RD;
                    end
                    else
                    begin
                        state_next = hfam_pkg::ST_OUT;
                    end
                end
            end
            hfam_pkg::ST_STORE_RD:   state_next = hfam_pkg::ST_STORE_WR;
            hfam_pkg::ST_STORE_WR:
            begin
                state_next = last_idx ? hfam_pkg::ST_OUT : hfam_pkg::ST_STORE_RD;
            end
            hfam_pkg::ST_RECALL_RD:  state_next = hfam_pkg::ST_RECALL_SUM;
            hfam_pkg::ST_RECALL_SUM: state_next = hfam_pkg::ST_RECALL_UPD;
            hfam_pkg::ST_RECALL_UPD:
            begin
                if (last_idx && (!chg || sweeps_inc == sweep_limit_reg))
                begin
                    state_next = hfam_pkg::ST_OUT;
                end
                else
                begin
                    state_next = hfam_pkg::ST_RECALL_RD;
                end
            end
            hfam_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = hfam_pkg::ST_IDLE;
                end
            end
            default: state_next = hfam_pkg::ST_IDLE;
        endcase
    end

    assign in_ready  = (state_reg == hfam_pkg::ST_IDLE);
    assign out_valid = (state_reg == hfam_pkg::ST_OUT);
    assign out_data  = out_reg;

    // pattern count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_count_reg <= '0;
        end
        else if (mem_clr)
        begin
            stored_count_reg <= '0;
        end
        else if (state_reg == hfam_pkg::ST_STORE_WR && last_idx)
        begin
            stored_count_reg <= stored_count_reg + 7'd1;
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            hfam_pkg::ST_IDLE:
            begin
                s_reg       <= in_data.pattern[NEURONS-1:0];
                ref_reg     <= in_data.reference_pattern[NEURONS-1:0];
                idx_reg     <= '0;
                sweeps_reg  <= '0;
                changed_reg <= 1'b0;
                out_reg     <= '0;
                if (in_data.mode == hfam_pkg::MODE_STORE)
                begin
                    out_reg.status <= (stored_count_reg >= 7'(MAX_PATTERNS));
                end
                if (in_data.mode == hfam_pkg::MODE_RECALL)
                begin
                    // zero limit: probe returned as is
                    out_reg.recalled_pattern  <= 64'(in_data.pattern[NEURONS-1:0]);
                    out_reg.matches_reference <= in_data.pattern[NEURONS-1:0]
                                                 == in_data.reference_pattern[NEURONS-1:0];
                end
            end
            hfam_pkg::ST_STORE_WR:
            begin
                idx_reg <= idx_reg + NW'(1);
            end
            hfam_pkg::ST_RECALL_SUM:
            begin
                for (int g = 0; g < GRP; g++)
                begin
                    psum_reg[g] <= psum_next[g];
                end
            end
            hfam_pkg::ST_RECALL_UPD:
            begin
                s_reg <= s_upd;
                if (last_idx)
                begin
                    idx_reg     <= '0;
                    changed_reg <= 1'b0;
                    sweeps_reg  <= sweeps_inc;
                    out_reg.recalled_pattern  <= 64'(s_upd);
                    out_reg.matches_reference <= (s_upd == ref_reg);
                    out_reg.converged         <= !chg;
                    out_reg.sweeps_used       <= sweeps_inc;
                end
                else
                begin
                    idx_reg     <= idx_reg + NW'(1);
                    changed_reg <= chg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
